/* hw/rtl/reed_pkg.sv */
// ----------------------------------------------------------------------------
// reed_pkg
// Shared types, constants and the quadrature transition table for the
// rotary encoder event decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package reed_pkg;

	// default width of stored timestamps
	localparam int TIME_BITS_DEF = 32;

	// field widths
	localparam int NOW_W   = 32;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 2;

	// configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_IDLE_RESET  = 2'd0,
		REG_LONG_PRESS  = 2'd1,
		REG_VLONG_PRESS = 2'd2
	} reg_idx_t;

	// configuration reset values
	localparam logic [CFG_W-1:0] IDLE_RESET_DEF  = 16'd300;
	localparam logic [CFG_W-1:0] LONG_PRESS_DEF  = 16'd1000;
	localparam logic [CFG_W-1:0] VLONG_PRESS_DEF = 16'd3000;

	// both channels high after reset
	localparam logic [1:0] PINS_RESET = 2'b11;

	// result codes
	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_NEXT  = 3'd1,
		EV_PREV  = 3'd2,
		EV_SHORT = 3'd3,
		EV_LONG  = 3'd4,
		EV_VLONG = 3'd5
	} evt_t;

	// step per transition: index is {previous A, previous B, A, B}
	function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
		logic signed [1:0] d;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
			default: d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/reed_if.sv */
// ----------------------------------------------------------------------------
// reed_if
// Valid/ready channels of the rotary encoder event decoder: pin samples in,
// events out, and the configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface reed_in_if;
	logic                          valid;
	logic                          ready;
	logic [reed_pkg::NOW_W-1:0]    now_ms;
	logic                          clk_level;
	logic                          dt_level;
	logic                          button_level;

	modport source (output valid, now_ms, clk_level, dt_level, button_level, input ready);
	modport sink   (input valid, now_ms, clk_level, dt_level, button_level, output ready);
endinterface

interface reed_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;

	modport source (output valid, event_res, input ready);
	modport sink   (input valid, event_res, output ready);
endinterface

interface reed_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [reed_pkg::CIDX_W-1:0] index;
	logic [reed_pkg::CFG_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rotary_encoder_event_decoder_unit.sv */
// ----------------------------------------------------------------------------
// rotary_encoder_event_decoder_unit
// Quadrature encoder decoder with button press classification.
// ----------------------------------------------------------------------------
// The block returns exactly one event word per poll: the poll is captured in
// an input register, then the transition lookup, idle check, step
// accumulation and press timing are done combinationally from it, and the
// decoder state and the result register are loaded together. A poll can
// enter every cycle while the result side keeps taking words; a stalled
// result holds in its register and the input register fills behind it.
// Configuration writes are taken at any time and must only be issued while
// no poll is in flight.
`default_nettype none

module rotary_encoder_event_decoder_unit #(
	parameter int TIME_BITS = reed_pkg::TIME_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	reed_in_if.sink    sample,
	reed_out_if.source result,
	reed_cfg_if.sink   cfg
);

	// configuration registers
	logic [reed_pkg::CFG_W-1:0] idle_reset_q;
	logic [reed_pkg::CFG_W-1:0] long_press_q;
	logic [reed_pkg::CFG_W-1:0] vlong_press_q;

	// decoder state
	logic [1:0]           prev_pins_q;
	logic signed [1:0]    step_count_q;
	logic [TIME_BITS-1:0] last_step_time_q;
	logic                 button_held_q;
	logic [TIME_BITS-1:0] press_start_q;

	// input stage
	logic                       valid_s1;
	logic [reed_pkg::NOW_W-1:0] now_ms_s1;
	logic [1:0]                 pins_s1;
	logic                       button_s1;

	// result stage
	logic            valid_s2;
	reed_pkg::evt_t  event_s2;

	// handshake
	logic advance;
	logic in_acc;

	// datapath
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] idle_elapsed;
	logic [TIME_BITS-1:0] held_time;
	logic signed [1:0]    count_eff;
	logic signed [1:0]    delta;
	logic signed [2:0]    sum;
	logic signed [1:0]    step_count_d;
	reed_pkg::evt_t       rot_evt;
	reed_pkg::evt_t       evt_d;
	logic                 button_held_d;
	logic                 down;

	assign cfg.ready = 1'b1;

	// move s1 into s2 when the result slot is free or being taken
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign in_acc       = sample.valid && sample.ready;

	assign result.valid     = valid_s2;
	assign result.event_res = event_s2;

	// rotation: idle discard, table lookup, accumulate
	always_comb begin
		now_t        = TIME_BITS'(now_ms_s1);
		idle_elapsed = now_t - last_step_time_q;
		if (step_count_q != 2'sd0 &&
		    idle_elapsed > TIME_BITS'(idle_reset_q)) begin
			count_eff = 2'sd0;
		end else begin
			count_eff = step_count_q;
		end
		delta        = reed_pkg::step_lookup({prev_pins_q, pins_s1});
		sum          = 3'(count_eff) + 3'(delta);
		rot_evt      = reed_pkg::EV_NONE;
		step_count_d = count_eff;
		if (delta != 2'sd0) begin
			if (sum == 3'sd2) begin
				rot_evt      = reed_pkg::EV_NEXT;
				step_count_d = 2'sd0;
			end else if (sum == -3'sd2) begin
				rot_evt      = reed_pkg::EV_PREV;
				step_count_d = 2'sd0;
			end else begin
				step_count_d = sum[1:0];
			end
		end
	end

	// button: only examined when no rotation event fired
	always_comb begin
		down          = !button_s1;
		held_time     = now_t - press_start_q;
		evt_d         = rot_evt;
		button_held_d = button_held_q;
		if (rot_evt == reed_pkg::EV_NONE) begin
			if (down && !button_held_q) begin
				button_held_d = 1'b1;
			end else if (!down && button_held_q) begin
				button_held_d = 1'b0;
				if (held_time >= TIME_BITS'(vlong_press_q)) begin
					evt_d = reed_pkg::EV_VLONG;
				end else if (held_time >= TIME_BITS'(long_press_q)) begin
					evt_d = reed_pkg::EV_LONG;
				end else begin
					evt_d = reed_pkg::EV_SHORT;
				end
			end
		end
	end

	// configuration writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_reset_q  <= reed_pkg::IDLE_RESET_DEF;
			long_press_q  <= reed_pkg::LONG_PRESS_DEF;
			vlong_press_q <= reed_pkg::VLONG_PRESS_DEF;
		end else if (cfg.valid) begin
			case (cfg.index)
				reed_pkg::REG_IDLE_RESET:  idle_reset_q  <= cfg.data;
				reed_pkg::REG_LONG_PRESS:  long_press_q  <= cfg.data;
				reed_pkg::REG_VLONG_PRESS: vlong_press_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_ms_s1 <= sample.now_ms;
			pins_s1   <= {sample.clk_level, sample.dt_level};
			button_s1 <= sample.button_level;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2 <= evt_d;
		end
	end

	// decoder state update, one poll per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pins_q      <= reed_pkg::PINS_RESET;
			step_count_q     <= 2'sd0;
			last_step_time_q <= '0;
			button_held_q    <= 1'b0;
			press_start_q    <= '0;
		end else if (advance) begin
			prev_pins_q   <= pins_s1;
			step_count_q  <= step_count_d;
			button_held_q <= button_held_d;
			if (delta != 2'sd0) begin
				last_step_time_q <= now_t;
			end
			if (rot_evt == reed_pkg::EV_NONE && down && !button_held_q) begin
				press_start_q <= now_t;
			end
		end
	end

`ifndef SYNTHESIS
	// a completed detent leaves no residual count
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (evt_d == reed_pkg::EV_NEXT || evt_d == reed_pkg::EV_PREV)
		|=> step_count_q == 2'sd0)
		else $error("residual count after rotation event");

	// the stored count never reaches a full detent
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> step_count_q != -2'sd2)
		else $error("stored step count out of range");

	// a press event needs a held button and releases it
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (evt_d == reed_pkg::EV_SHORT || evt_d == reed_pkg::EV_LONG ||
		            evt_d == reed_pkg::EV_VLONG)
		|-> button_held_q ##1 !button_held_q)
		else $error("press event without held button");

	// an accepted poll lands in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted poll lost");

	// a stalled result is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready |=> valid_s2 && $stable(event_s2))
		else $error("result overwritten under stall");
`endif

endmodule

`default_nettype wire
